[hw/rtl/bf3_pkg.sv]
// Package for the 3x3 box filter: pixel, column and result-queue types,
// fixed field widths, register codes and reset values.
// No dependencies; used by every module of the block except bf3_ram.
`default_nettype none

package bf3_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_DATA_W = 32;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam int WIN_COLS  = 3;
    localparam int COL_SUM_W = 10;   // 3 * 255
    localparam int WIN_SUM_W = 12;   // 9 * 255

    // floor(x / 9) == (x * 3641) >> 15 for all x <= 2295
    localparam int DIV9_MUL   = 3641;
    localparam int DIV9_SHIFT = 15;
    localparam int DIV9_PROD_W = 24;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [COORD_W-1:0] coord_t;

    // one window column: top is row r-2, bot is row r
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } col_t;

    // all results caused by one input item
    typedef struct packed {
        logic   int_v;
        pixel_t int_pix;
        coord_t int_row;
        coord_t int_col;
        logic   bord_v;
        pixel_t bord_pix;
        coord_t bord_row;
        coord_t bord_col;
    } rq_entry_t;

endpackage

`default_nettype wire

[hw/rtl/bf3_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (read-first on an address collision). No dependencies.
`default_nettype none

module bf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bf3_cell.sv]
// One column cell of the 3x3 window chain: holds a column of three pixels
// and takes its neighbor's column on each shift. Depends on bf3_pkg.
`default_nettype none

module bf3_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            shift_en,
    input  bf3_pkg::col_t                   col_in,
    output bf3_pkg::col_t                   col_out,
    output logic [bf3_pkg::COL_SUM_W-1:0]   col_sum
);

    localparam int SW = bf3_pkg::COL_SUM_W;

    bf3_pkg::col_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    // sum of the held column, taken in the cycle after the shift
    assign col_sum = SW'(col_reg.top) + SW'(col_reg.mid) + SW'(col_reg.bot);

endmodule

`default_nettype wire

[hw/rtl/bf3_rqueue.sv]
// Result queue: one entry per input item that gives results, emitted as
// one or two output items (interior mean first). Depends on bf3_pkg.
`default_nettype none

module bf3_rqueue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  bf3_pkg::rq_entry_t            push_entry,
    output logic [bf3_pkg::RQ_CNT_W-1:0]  count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bf3_pkg::pixel_t               out_pix,
    output bf3_pkg::coord_t               out_row,
    output bf3_pkg::coord_t               out_col,
    output logic                          out_last
);

    localparam int PW = bf3_pkg::RQ_PTR_W;

    bf3_pkg::rq_entry_t          entry_reg [bf3_pkg::RQ_DEPTH];
    logic [PW-1:0]               wr_ptr_reg;
    logic [PW-1:0]               rd_ptr_reg;
    logic [bf3_pkg::RQ_CNT_W-1:0] count_reg;
    logic                        phase_reg;   // interior part already sent

    bf3_pkg::rq_entry_t head;
    logic               pick_int;
    logic               pop;

    assign head     = entry_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign pick_int = head.int_v && !phase_reg;

    always_comb begin
        if (pick_int) begin
            out_pix  = head.int_pix;
            out_row  = head.int_row;
            out_col  = head.int_col;
            out_last = !head.bord_v;
        end else begin
            out_pix  = head.bord_pix;
            out_row  = head.bord_row;
            out_col  = head.bord_col;
            out_last = 1'b1;
        end
    end

    assign pop   = out_valid && out_ready && out_last;
    assign count = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= PW'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
            if (pop) begin
                phase_reg <= 1'b0;
            end else if (out_valid && out_ready) begin
                phase_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/box_filter_3x3_top.sv]
// 3x3 box filter top level: position counters, two line-store RAMs, the
// window cell chain, divide-by-9 stage and result queue.
// Depends on bf3_pkg, bf3_ram, bf3_cell, bf3_rqueue.
//
//  channel | ports               | item
//  --------+---------------------+-----------------------------------------
//  input   | s_tvalid/s_tready   | tdata: pixel_in; tuser: frame_start
//  result  | m_tvalid/m_tready   | tdata: pixel_out, out_row, out_col; tlast
//  config  | cfg_valid/cfg_ready | cfg_index selects register, cfg_data value
//
// One input item per clock sustained while s_tready is high. From input to
// result: line-store RAM read, window shift, then window sum and divide by 9
// (multiply) into the queue. An input item can give two result items, so the
// output side sets the long-term rate when many border pixels appear back to back.
// Reset is synchronous, active low; the line stores need no clearing pass.
// s_tready drops only when the four-entry result queue could overflow.
`default_nettype none

module box_filter_3x3_top #(
    parameter int MAX_WIDTH  = bf3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bf3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel_in
    input  logic                              s_tuser,   // [0] frame_start
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bf3_pkg::OUT_DATA_W-1:0]    m_tdata,   // [7:0] pixel_out,
                                                         // [17:8] out_row,
                                                         // [27:18] out_col
    output logic                              m_tlast,   // last_of_item
    // config writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam int XW  = bf3_pkg::COORD_W;
    localparam int SUW = bf3_pkg::WIN_SUM_W;
    localparam int PRW = bf3_pkg::DIV9_PROD_W;
    localparam int QCW = bf3_pkg::RQ_CNT_W;
    localparam int NC  = bf3_pkg::WIN_COLS;

    localparam int W_RST = (MAX_WIDTH < bf3_pkg::IMAGE_WIDTH_RESET) ?
                           MAX_WIDTH : bf3_pkg::IMAGE_WIDTH_RESET;
    localparam int H_RST = (MAX_HEIGHT < bf3_pkg::IMAGE_HEIGHT_RESET) ?
                           MAX_HEIGHT : bf3_pkg::IMAGE_HEIGHT_RESET;

    // ---------------- configuration (stored already clamped) ----------------
    logic [WDW-1:0] w_reg;
    logic [HDW-1:0] h_reg;
    logic [WDW-1:0] w_clamp;
    logic [HDW-1:0] h_clamp;
    logic           cfg_accept;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign w_clamp = (cfg_data == '0) ? WDW'(1) :
                     (32'(cfg_data) > MAX_WIDTH) ? WDW'(MAX_WIDTH) : WDW'(cfg_data);
    assign h_clamp = (cfg_data == '0) ? HDW'(1) :
                     (32'(cfg_data) > MAX_HEIGHT) ? HDW'(MAX_HEIGHT) : HDW'(cfg_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= WDW'(W_RST);
            h_reg <= HDW'(H_RST);
        end else if (cfg_accept) begin
            case (cfg_index)
                bf3_pkg::CFG_IMAGE_WIDTH:  w_reg <= w_clamp;
                bf3_pkg::CFG_IMAGE_HEIGHT: h_reg <= h_clamp;
                default: ;
            endcase
        end
    end

    // ---------------- stage A: position, RAM read ----------------
    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic           s_accept;
    logic [CW-1:0]  c0;
    logic [RW-1:0]  r0;
    logic [CW-1:0]  c_a;
    logic [HDW-1:0] r1;
    logic [RW-1:0]  r_a;
    logic [WDW-1:0] cn;
    logic [HDW-1:0] rn;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_next;
    logic           int_a;
    logic           bord_a;

    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        c0 = s_tuser ? '0 : col_reg;
        r0 = s_tuser ? '0 : row_reg;
        // wrap a column left past the end by a geometry change
        if (WDW'(c0) >= w_reg) begin
            c_a = '0;
            r1  = HDW'(r0) + 1'b1;
        end else begin
            c_a = c0;
            r1  = HDW'(r0);
        end
        r_a = (r1 >= h_reg) ? '0 : RW'(r1);

        cn = WDW'(c_a) + 1'b1;
        rn = HDW'(r_a) + 1'b1;
        if (cn >= w_reg) begin
            col_next = '0;
            row_next = (rn >= h_reg) ? '0 : RW'(rn);
        end else begin
            col_next = CW'(cn);
            row_next = r_a;
        end

        int_a  = (r_a >= RW'(2)) && (c_a >= CW'(2));
        bord_a = (r_a == '0) || (HDW'(r_a) == h_reg - 1'b1) ||
                 (c_a == '0) || (WDW'(c_a) == w_reg - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage B: line stores, window shift ----------------
    logic                vb_reg;
    bf3_pkg::pixel_t     pix_b_reg;
    logic [CW-1:0]       c_b_reg;
    logic [RW-1:0]       r_b_reg;
    logic                int_b_reg;
    logic                bord_b_reg;
    logic                fwd_reg;
    bf3_pkg::pixel_t     fwd_up_reg;
    bf3_pkg::pixel_t     fwd_mid_reg;

    bf3_pkg::pixel_t     up_q;
    bf3_pkg::pixel_t     mid_q;
    bf3_pkg::pixel_t     up_eff;
    bf3_pkg::pixel_t     mid_eff;
    bf3_pkg::col_t       new_col;
    bf3_pkg::col_t       win_col [NC];
    bf3_pkg::col_t       win_in  [NC];
    logic [bf3_pkg::COL_SUM_W-1:0] win_csum [NC];

    bf3_ram #(
        .WIDTH (bf3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .aclk  (aclk),
        .we    (vb_reg),
        .waddr (c_b_reg),
        .wdata (mid_eff),
        .re    (s_accept),
        .raddr (c_a),
        .rdata (up_q)
    );

    bf3_ram #(
        .WIDTH (bf3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .aclk  (aclk),
        .we    (vb_reg),
        .waddr (c_b_reg),
        .wdata (pix_b_reg),
        .re    (s_accept),
        .raddr (c_a),
        .rdata (mid_q)
    );

    // a write to the same column in the read cycle is not in the RAM data yet
    assign up_eff  = fwd_reg ? fwd_up_reg  : up_q;
    assign mid_eff = fwd_reg ? fwd_mid_reg : mid_q;

    assign new_col.top = up_eff;
    assign new_col.mid = mid_eff;
    assign new_col.bot = pix_b_reg;

    genvar k;
    generate
        for (k = 0; k < NC; k++) begin : g_cell
            if (k == NC - 1) begin : g_head
                assign win_in[k] = new_col;
            end else begin : g_link
                assign win_in[k] = win_col[k + 1];
            end
            bf3_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (vb_reg),
                .col_in   (win_in[k]),
                .col_out  (win_col[k]),
                .col_sum  (win_csum[k])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg  <= 1'b0;
            fwd_reg <= 1'b0;
        end else begin
            vb_reg  <= s_accept;
            fwd_reg <= vb_reg && (c_b_reg == c_a);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix_b_reg   <= s_tdata;
            c_b_reg     <= c_a;
            r_b_reg     <= r_a;
            int_b_reg   <= int_a;
            bord_b_reg  <= bord_a;
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= pix_b_reg;
        end
    end

    // ---------------- stage C: window sum, divide by 9, push results ----------------
    logic                vc_reg;
    logic [SUW-1:0]      sum_c;
    bf3_pkg::pixel_t     pix_c_reg;
    logic [CW-1:0]       c_c_reg;
    logic [RW-1:0]       r_c_reg;
    logic                int_c_reg;
    logic                bord_c_reg;
    logic [PRW-1:0]      prod;
    bf3_pkg::rq_entry_t  push_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else begin
            vc_reg <= vb_reg && (int_b_reg || bord_b_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (vb_reg) begin
            pix_c_reg  <= pix_b_reg;
            c_c_reg    <= c_b_reg;
            r_c_reg    <= r_b_reg;
            int_c_reg  <= int_b_reg;
            bord_c_reg <= bord_b_reg;
        end
    end

    // the cells hold this item's window until the next shift
    assign sum_c = SUW'(win_csum[0]) + SUW'(win_csum[1]) + SUW'(win_csum[2]);
    assign prod  = PRW'(sum_c) * PRW'(bf3_pkg::DIV9_MUL);

    assign push_entry.int_v    = int_c_reg;
    assign push_entry.int_pix  = prod[bf3_pkg::DIV9_SHIFT +: bf3_pkg::PIX_W];
    assign push_entry.int_row  = XW'(r_c_reg - 1'b1);
    assign push_entry.int_col  = XW'(c_c_reg - 1'b1);
    assign push_entry.bord_v   = bord_c_reg;
    assign push_entry.bord_pix = pix_c_reg;
    assign push_entry.bord_row = XW'(r_c_reg);
    assign push_entry.bord_col = XW'(c_c_reg);

    // ---------------- result queue and output ----------------
    logic [QCW-1:0]   q_count;
    logic [QCW+1:0]   q_need;
    bf3_pkg::pixel_t  out_pix;
    bf3_pkg::coord_t  out_row;
    bf3_pkg::coord_t  out_col;

    bf3_rqueue u_rqueue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (vc_reg),
        .push_entry (push_entry),
        .count      (q_count),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pix    (out_pix),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_last   (m_tlast)
    );

    // room for everything in flight plus the item offered now
    assign q_need   = (QCW+2)'(q_count) + (QCW+2)'(vb_reg) + (QCW+2)'(vc_reg);
    assign s_tready = (q_need <= (QCW+2)'(bf3_pkg::RQ_DEPTH - 1));

    assign m_tdata = {4'b0000, out_col, out_row, out_pix};

endmodule

`default_nettype wire

[bench/bf3_checker.sv]
`timescale 1ns / 100ps
// Result checker for the 3x3 box filter: watches the config, input and result
// channels, predicts every result item and compares it field by field.
// Depends on bf3_pkg only.

module bf3_checker
    import bf3_pkg::*;
#(
    parameter int MAX_W = DEF_MAX_WIDTH,
    parameter int MAX_H = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen
);

    localparam int REPORT_MAX = 10;

    typedef struct {
        pixel_t pix;
        coord_t row;
        coord_t col;
        logic   last;
    } pixel_result_t;

    pixel_result_t expected_pixels[$];

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    pixel_t                upper_row  [MAX_W];
    pixel_t                middle_row [MAX_W];
    pixel_t                win        [9];
    int unsigned           row_pos;
    int unsigned           col_pos;

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        for (int i = 0; i < MAX_W; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
    end

    function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    // Advance the filter by one source pixel and queue the result items it causes.
    task automatic mean_filter_pixel(pixel_t pix, logic fs);
        int unsigned   w, h, r, c, sum;
        pixel_t        up, mid;
        bit            is_int, is_bord;
        pixel_result_t res;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        if (fs) begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        r = row_pos;
        c = col_pos;

        up            = upper_row[c];
        mid           = middle_row[c];
        upper_row[c]  = mid;
        middle_row[c] = pix;

        for (int i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = pix;

        is_int  = (r >= 2) && (c >= 2);
        is_bord = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);

        // interior result lags one row and one column behind the input
        if (is_int) begin
            sum = 0;
            for (int i = 0; i < 9; i++)
                sum += win[i];
            res.pix  = pixel_t'(sum / 9);
            res.row  = coord_t'(r - 1);
            res.col  = coord_t'(c - 1);
            res.last = !is_bord;
            expected_pixels.push_back(res);
        end
        if (is_bord) begin
            res.pix  = pix;
            res.row  = coord_t'(r);
            res.col  = coord_t'(c);
            res.last = 1'b1;
            expected_pixels.push_back(res);
        end

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    always @(posedge aclk) begin : watch
        pixel_result_t got_r, exp_r;
        if (!aresetn) begin
            width_reg  = CFG_DATA_W'(IMAGE_WIDTH_RESET);
            height_reg = CFG_DATA_W'(IMAGE_HEIGHT_RESET);
            for (int i = 0; i < 9; i++)
                win[i] = '0;
            row_pos = 0;
            col_pos = 0;
            expected_pixels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  = cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                mean_filter_pixel(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                got_r.pix  = m_tdata[7:0];
                got_r.row  = m_tdata[17:8];
                got_r.col  = m_tdata[27:18];
                got_r.last = m_tlast;
                if (expected_pixels.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("[%0t] unexpected result item: pix %0d row %0d col %0d last %0b",
                                 $realtime, got_r.pix, got_r.row, got_r.col, got_r.last);
                    fail_count++;
                end else begin
                    exp_r = expected_pixels.pop_front();
                    if (got_r.pix !== exp_r.pix || got_r.row !== exp_r.row ||
                        got_r.col !== exp_r.col || got_r.last !== exp_r.last) begin
                        if (fail_count < REPORT_MAX) begin
                            $display("[%0t] result %0d mismatch", $realtime, results_seen);
                            $display("    expected pix %0d row %0d col %0d last %0b",
                                     exp_r.pix, exp_r.row, exp_r.col, exp_r.last);
                            $display("    got      pix %0d row %0d col %0d last %0b",
                                     got_r.pix, got_r.row, got_r.col, got_r.last);
                        end
                        fail_count++;
                    end
                end
                results_seen++;
            end
        end
        pending = expected_pixels.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Bench top for box_filter_3x3_top: clock, reset, pixel and config stimulus,
// result-side back-pressure and the verdict. Depends on bf3_pkg, bf3_checker and box_filter_3x3_top.

module tb;
    import bf3_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 100;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 480;
    localparam int EXTREME_RUN  = 1026;
    localparam int NARROW_RUN   = 24;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int results_seen;
    bit idle_on = 1'b0;

    always #5 aclk = ~aclk;

    box_filter_3x3_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bf3_checker u_mon (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // Entered and left at a falling edge; leaves s_tvalid high.
    task automatic push_pixel(pixel_t pix, logic fs);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Drain the block, then load a new frame geometry.
    task automatic set_geometry(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Result-side ready: random gap after each item while idle_on is set, one long hold-off.
    initial begin : sink
        int  seen_last;
        int  gap_left;
        int  hold_left;
        bit  held;
        seen_last = 0;
        gap_left  = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge aclk);
            if (results_seen != seen_last) begin
                seen_last = results_seen;
                gap_left  = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (!held && results_seen >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (aresetn);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("** box_filter_3x3_top: FAILED **");
        $finish;
    end

    initial begin : stim
        int unsigned     w_sel, h_sel, n_frames, frame_len;
        int unsigned     rand_items;
        logic [CFG_DATA_W-1:0] w_reg, h_reg;
        bit              flat, lead_fs;
        pixel_t          pix;
        logic            fs;

        rand_items = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset geometry first, then a 3x3 frame
        idle_on = 1'b1;
        push_pixel(8'hFF, 1'b1);
        push_pixel(8'h00, 1'b0);
        set_geometry(11'd3, 11'd3);
        // all-255 frame: largest window sum, two items at the bottom-right corner
        for (int i = 0; i < 9; i++)
            push_pixel(8'hFF, i == 0);
        for (int i = 0; i < 4; i++)
            push_pixel(8'h00, i == 0);
        // frame_start mid-frame restarts at row 0, column 0
        for (int i = 0; i < 9; i++)
            push_pixel(pixel_t'(i * 37), i == 0);

        // width above the maximum clamps to 1024; single-row frames wrap
        set_geometry(11'd2047, 11'd1);
        for (int i = 0; i < EXTREME_RUN; i++)
            push_pixel(pixel_t'($urandom_range(0, 255)), i == 0);
        // width 0 counts as 1, height above the maximum clamps to 1024
        idle_on = 1'b0;
        set_geometry(11'd0, 11'd2047);
        for (int i = 0; i < NARROW_RUN; i++)
            push_pixel(pixel_t'($urandom_range(0, 255)), i == 0);

        while (rand_items < RANDOM_ITEMS) begin
            w_sel = $urandom_range(0, 9);
            h_sel = $urandom_range(0, 9);
            case (w_sel)
                0:       w_reg = 11'd1;
                1:       w_reg = 11'd2;
                2:       w_reg = CFG_DATA_W'($urandom_range(20, 40));
                default: w_reg = CFG_DATA_W'($urandom_range(3, 12));
            endcase
            case (h_sel)
                0:       h_reg = 11'd1;
                1:       h_reg = 11'd2;
                default: h_reg = CFG_DATA_W'($urandom_range(3, 8));
            endcase
            set_geometry(w_reg, h_reg);
            idle_on   = ($urandom_range(0, 3) != 0);
            n_frames  = $urandom_range(1, 3);
            frame_len = w_reg * h_reg;
            for (int f = 0; f < n_frames; f++) begin
                flat    = ($urandom_range(0, 9) == 0);
                // first frame after a geometry change always starts explicitly
                lead_fs = (f == 0) || ($urandom_range(0, 4) != 0);
                for (int p = 0; p < frame_len; p++) begin
                    if (flat)
                        pix = 8'hFF;
                    else if ($urandom_range(0, 4) == 0)
                        pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    else
                        pix = pixel_t'($urandom_range(0, 255));
                    fs = (p == 0) ? lead_fs : ($urandom_range(0, 99) < 2);
                    push_pixel(pix, fs);
                    rand_items++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("** box_filter_3x3_top: PASSED **");
        else
            $display("** box_filter_3x3_top: FAILED **");
        $finish;
    end

endmodule
